/* sv/cfh_pkg.sv */
package cfh_pkg;

	localparam logic [7:0] FIRST_CODE = 8'd32;

	typedef enum logic {
		OP_COUNT = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] character;
		logic [6:0] bin_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0] bin_count;
		logic [6:0]  char_code;
		logic        bin_present;
		logic [15:0] peak_count;
	} out_item_t;

endpackage

/* sv/cfh_stream_if.sv */
interface cfh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/character_frequency_histogram.sv */
// Byte histogram of printable characters. One saturating counter per bin
// (bin b counts code 32 + b) lives in a synchronous RAM; a count item reads
// its bin, adds one in the following cycle and writes it back, raising the
// running peak as it goes. A read item returns one bin with its code, a
// nonzero flag and the peak. Bytes outside the bins are dropped silently.
// Throughput is one item per cycle while the input is not stalled; a read
// result is loaded from stage 1 into the output register. The last written
// count is forwarded round the bin RAM's read-modify-write loop, so the same
// bin may repeat in consecutive cycles. Input stalls only while a read item
// in stage 1 waits for the full output register. Per-bin valid flops make the
// store read as zero straight after reset, so no clearing pass is needed.
module character_frequency_histogram
	import cfh_pkg::*;
#(
	parameter int NUM_BINS    = 94,
	parameter int COUNT_WIDTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	cfh_stream_if.sink   feed,
	cfh_stream_if.source report
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// accept side
	logic       accept;
	logic [7:0] offset;
	logic [8:0] req_idx;
	logic       req_hit;

	// stage 1
	logic          valid_s1;
	op_t           op_s1;
	logic          hit_s1;
	logic [AW-1:0] addr_s1;
	logic [6:0]    code_s1;
	logic          stall_s1;

	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] next_cnt;
	logic                   wr_en;
	logic                   rd_load;
	logic                   fwd_hit;
	logic [31:0]            cur_ext;
	logic [31:0]            peak_ext;

	logic [NUM_BINS-1:0]    bin_valid_q;
	logic                   fwd_valid_q;
	logic [AW-1:0]          fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;
	logic [COUNT_WIDTH-1:0] peak_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	assign accept = feed.valid && feed.ready;
	assign offset = feed.payload.character - FIRST_CODE;

	always_comb begin
		if (feed.payload.operation == OP_COUNT) begin
			req_idx = {1'b0, offset};
			req_hit = (feed.payload.character >= FIRST_CODE) && (req_idx < 9'(NUM_BINS));
		end else begin
			req_idx = {2'b00, feed.payload.bin_index};
			req_hit = req_idx < 9'(NUM_BINS);
		end
	end

	cfh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(next_cnt),
		.re   (accept),
		.raddr(req_idx[AW-1:0]),
		.rdata(rdata)
	);

	assign stall_s1 = valid_s1 && (op_s1 == OP_READ) && out_valid_q && !report.ready;
	assign feed.ready = !stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= feed.payload.operation;
			hit_s1  <= req_hit;
			addr_s1 <= req_idx[AW-1:0];
			code_s1 <= feed.payload.bin_index + 7'(FIRST_CODE);
		end
	end

	// the last write is always the newest value of its bin
	assign fwd_hit = fwd_valid_q && (fwd_addr_q == addr_s1);

	always_comb begin
		if (!hit_s1) begin
			cur = '0;
		end else if (fwd_hit) begin
			cur = fwd_data_q;
		end else if (bin_valid_q[addr_s1]) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
	end

	assign next_cnt = (cur == CNT_MAX) ? cur : cur + 1'b1;
	assign wr_en    = valid_s1 && (op_s1 == OP_COUNT) && hit_s1;
	assign rd_load  = valid_s1 && (op_s1 == OP_READ) && !stall_s1;
	assign cur_ext  = 32'(cur);
	assign peak_ext = 32'(peak_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			fwd_valid_q <= 1'b0;
			peak_q      <= '0;
		end else if (wr_en) begin
			bin_valid_q[addr_s1] <= 1'b1;
			fwd_valid_q          <= 1'b1;
			if (next_cnt > peak_q) begin
				peak_q <= next_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= next_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_load) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_load) begin
			out_q.bin_count   <= cur_ext[15:0];
			out_q.char_code   <= code_s1;
			out_q.bin_present <= (cur != '0);
			out_q.peak_count  <= peak_ext[15:0];
		end
	end

	assign report.valid   = out_valid_q;
	assign report.payload = out_q;

`ifndef SYNTHESIS
	a_peak_covers_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> peak_q >= $past(next_cnt))
		else $error("peak below a written count");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> peak_q >= $past(peak_q))
		else $error("peak decreased");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> next_cnt != '0)
		else $error("bin counter wrapped");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall_s1 |=> valid_s1 && $stable(addr_s1) && $stable(code_s1))
		else $error("stalled read item lost");
`endif

endmodule

/* sv/cfh_ram.sv */
module cfh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 94,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
